[rtl/core/dblp_pkg.sv]
// Shared constants for the dual breathing LED PWM block.
`timescale 1ns / 1ps
`default_nettype none

package dblp_pkg;

    localparam int UPTIME_BITS_DEF = 32;
    localparam int ELAPSED_W       = 32;
    localparam int VAL_W           = 16;
    localparam int CFG_IDX_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GEN1_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GEN1_STEPS  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GEN2_PERIOD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GEN2_STEPS  = 8'd3;

    localparam logic [VAL_W-1:0] PERIOD_RESET = 16'd0;
    localparam logic [VAL_W-1:0] STEPS_RESET  = 16'd1;

endpackage

`default_nettype wire

[rtl/core/dual_breathing_led_pwm.sv]
// Top level of the dual breathing LED PWM block with its shared divider and sequencer.
//
// Usage: each request on the input channel carries elapsed_time, the microseconds since
// the previous request. It is added to a wrapping uptime counter, and both breathing
// generators are then evaluated against the new uptime. One result request follows per
// input request, carrying gen1_on, gen2_on and led_level (always equal to gen2_on).
// Configuration requests write gen1_period, gen1_steps, gen2_period and gen2_steps by
// index 0 to 3; other indexes are ignored. Write them only while the block is idle.
// An enabled generator runs three divisions on one shared restoring divider that retires
// one quotient bit per cycle, where DW is the larger of UPTIME_BITS and 32. A disabled
// generator skips the divisions. While an item is in progress in_ready is low, and the
// next request is accepted once the sequencer is back in its idle state.
// The result sits in an output register, so the next input is accepted while it waits.
// If the receiver stalls and a second result is finished, the sequencer holds it until
// the output register frees up.
// Reset clears the uptime, sets both periods to 0 (disabled) and both step counts to 1.
`timescale 1ns / 1ps
`default_nettype none

module dual_breathing_led_pwm #(
    parameter int UPTIME_BITS = dblp_pkg::UPTIME_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [dblp_pkg::ELAPSED_W-1:0] elapsed_time,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                gen1_on,
    output logic                                gen2_on,
    output logic                                led_level,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dblp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dblp_pkg::VAL_W-1:0]     cfg_data
);

    localparam int DW = (UPTIME_BITS > dblp_pkg::ELAPSED_W) ? UPTIME_BITS
                                                             : dblp_pkg::ELAPSED_W;
    localparam int CW = $clog2(DW);
    localparam int VW = dblp_pkg::VAL_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_START = 8'b00000010,
        ST_DIV_A = 8'b00000100,
        ST_DIV_B = 8'b00001000,
        ST_MUL   = 8'b00010000,
        ST_DIV_C = 8'b00100000,
        ST_CMP   = 8'b01000000,
        ST_NEXT  = 8'b10000000
    } state_t;

    state_t                 state_reg;
    logic                   gen_reg;
    logic [UPTIME_BITS-1:0] uptime_reg;
    logic [VW-1:0]          gen1_period_reg;
    logic [VW-1:0]          gen1_steps_reg;
    logic [VW-1:0]          gen2_period_reg;
    logic [VW-1:0]          gen2_steps_reg;
    logic [DW-1:0]          dividend_reg;
    logic [VW-1:0]          rem_reg;
    logic [VW-1:0]          den_reg;
    logic [CW-1:0]          cnt_reg;
    logic [VW-1:0]          phase_reg;
    logic [VW-1:0]          step_reg;
    logic [VW-1:0]          duty_reg;
    logic                   odd_reg;
    logic [1:0]             res_reg;
    logic                   out_valid_reg;
    logic                   gen1_on_reg;
    logic                   gen2_on_reg;

    logic [DW-1:0]          uptime_sum;
    logic [VW-1:0]          cur_period;
    logic [VW-1:0]          cur_steps;
    logic [VW:0]            trial;
    logic [VW:0]            diff;
    logic                   quot_bit;
    logic [VW-1:0]          rem_next;
    logic [DW-1:0]          quot_next;
    logic [2*VW-1:0]        product;
    logic [VW-1:0]          duty_eff;
    logic                   out_free;
    logic                   div_last;
    logic                   result_load;

    assign uptime_sum = DW'(uptime_reg) + DW'(elapsed_time);
    assign cur_period = gen_reg ? gen2_period_reg : gen1_period_reg;
    assign cur_steps  = (gen_reg ? gen2_steps_reg : gen1_steps_reg) == '0 ? VW'(1)
                      : (gen_reg ? gen2_steps_reg : gen1_steps_reg);

    assign trial     = {rem_reg, dividend_reg[DW-1]};
    assign diff      = trial - {1'b0, den_reg};
    assign quot_bit  = !diff[VW];
    assign rem_next  = quot_bit ? diff[VW-1:0] : trial[VW-1:0];
    assign quot_next = {dividend_reg[DW-2:0], quot_bit};
    assign div_last  = cnt_reg == '0;

    assign product  = {{VW{1'b0}}, cur_period} * {{VW{1'b0}}, step_reg};
    assign duty_eff = odd_reg ? (cur_period - duty_reg) : duty_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign result_load = (state_reg == ST_NEXT) && gen_reg && out_free;

    assign in_ready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign gen1_on   = gen1_on_reg;
    assign gen2_on   = gen2_on_reg;
    assign led_level = gen2_on_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen1_period_reg <= dblp_pkg::PERIOD_RESET;
            gen1_steps_reg  <= dblp_pkg::STEPS_RESET;
            gen2_period_reg <= dblp_pkg::PERIOD_RESET;
            gen2_steps_reg  <= dblp_pkg::STEPS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dblp_pkg::REG_GEN1_PERIOD: gen1_period_reg <= cfg_data;
                dblp_pkg::REG_GEN1_STEPS:  gen1_steps_reg  <= cfg_data;
                dblp_pkg::REG_GEN2_PERIOD: gen2_period_reg <= cfg_data;
                dblp_pkg::REG_GEN2_STEPS:  gen2_steps_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= 1'b0;
            uptime_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            dividend_reg  <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            phase_reg     <= '0;
            step_reg      <= '0;
            duty_reg      <= '0;
            odd_reg       <= 1'b0;
            res_reg       <= '0;
            gen1_on_reg   <= 1'b0;
            gen2_on_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !result_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        uptime_reg <= uptime_sum[UPTIME_BITS-1:0];
                        gen_reg    <= 1'b0;
                        state_reg  <= ST_START;
                    end
                end
                ST_START:
                begin
                    if (cur_period == '0)
                    begin
                        res_reg[gen_reg] <= !gen_reg;
                        state_reg        <= ST_NEXT;
                    end
                    else
                    begin
                        dividend_reg <= DW'(uptime_reg);
                        rem_reg      <= '0;
                        den_reg      <= cur_period;
                        cnt_reg      <= CW'(DW - 1);
                        state_reg    <= ST_DIV_A;
                    end
                end
                ST_DIV_A:
                begin
                    if (div_last)
                    begin
                        phase_reg    <= rem_next;
                        dividend_reg <= quot_next;
                        rem_reg      <= '0;
                        den_reg      <= cur_steps;
                        cnt_reg      <= CW'(DW - 1);
                        state_reg    <= ST_DIV_B;
                    end
                    else
                    begin
                        cnt_reg      <= cnt_reg - CW'(1);
                        dividend_reg <= quot_next;
                        rem_reg      <= rem_next;
                    end
                end
                ST_DIV_B:
                begin
                    cnt_reg      <= cnt_reg - CW'(1);
                    dividend_reg <= quot_next;
                    rem_reg      <= rem_next;
                    if (div_last)
                    begin
                        odd_reg   <= quot_bit;
                        step_reg  <= rem_next;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    dividend_reg <= DW'(product);
                    rem_reg      <= '0;
                    cnt_reg      <= CW'(DW - 1);
                    state_reg    <= ST_DIV_C;
                end
                ST_DIV_C:
                begin
                    cnt_reg      <= cnt_reg - CW'(1);
                    dividend_reg <= quot_next;
                    rem_reg      <= rem_next;
                    if (div_last)
                    begin
                        duty_reg  <= quot_next[VW-1:0];
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    res_reg[gen_reg] <= phase_reg > duty_eff;
                    state_reg        <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    if (!gen_reg)
                    begin
                        gen_reg   <= 1'b1;
                        state_reg <= ST_START;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        gen1_on_reg   <= res_reg[0];
                        gen2_on_reg   <= res_reg[1];
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_START && !gen_reg))
        else $error("accepted request did not start the first generator");

    a_result_from_next: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_NEXT && $past(gen_reg)))
        else $error("result raised outside the final sequencer step");

    a_div_a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_A && div_last) |=> (state_reg == ST_DIV_B))
        else $error("first division did not hand over to the second");

    a_gen1_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START && !gen_reg && gen1_period_reg == '0) |=> res_reg[0])
        else $error("disabled first generator did not report on");

endmodule

`default_nettype wire
